@@ hw/rtl/bamboo_shaker_synth_unit_defines.svh @@
// Assertion macros shared by the bamboo shaker RTL.
`ifndef BAMBOO_SHAKER_SYNTH_UNIT_DEFINES_SVH
`define BAMBOO_SHAKER_SYNTH_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define BSS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bss_pkg.sv @@
// Shared types, constants and cosine-table functions for the bamboo shaker.
package bss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TUBE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RES_FREQ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RES_SPREAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RES_RANDOM   = 3'd5;

    localparam logic [12:0] RST_TUBE_COUNT   = 13'd5;
    localparam logic [27:0] RST_LEVEL_GAIN   = 28'd13421773;
    localparam logic [24:0] RST_SYSTEM_DECAY = 25'd16776378;
    localparam logic [23:0] RST_RES_FREQ     = 24'd1521747;

    // input item field offsets in s_tdata
    localparam int F_DRAW_LSB  = 0;
    localparam int F_NC_LSB    = 13;
    localparam int F_NL_LSB    = 28;
    localparam int F_NU_LSB    = 43;
    localparam int F_NE_LSB    = 58;
    localparam int F_SHAKE_LSB = 73;

    // datapath operations
    localparam int OP_W = 5;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_NONE = 5'd0;
    localparam op_t OP_LOAD = 5'd1;
    localparam op_t OP_E1   = 5'd2;   // energy += shake * 0.1
    localparam op_t OP_E2   = 5'd3;   // energy *= system_decay
    localparam op_t OP_C1   = 5'd4;   // level += gain * energy
    localparam op_t OP_RJ   = 5'd5;   // jitter product
    localparam op_t OP_PH   = 5'd6;   // phase = freq * factor
    localparam op_t OP_CS   = 5'd7;   // cosine table read
    localparam op_t OP_CF   = 5'd8;   // coefficient = -2r * cos
    localparam op_t OP_XL   = 5'd9;
    localparam op_t OP_XH   = 5'd10;
    localparam op_t OP_DL   = 5'd11;
    localparam op_t OP_DH   = 5'd12;
    localparam op_t OP_R0L  = 5'd13;
    localparam op_t OP_R0H  = 5'd14;
    localparam op_t OP_R1L  = 5'd15;
    localparam op_t OP_R1H  = 5'd16;
    localparam op_t OP_OUT  = 5'd17;

    typedef struct packed {
        op_t        op;
        logic [1:0] ridx;
    } dp_cmd_t;

    typedef struct packed {
        logic collide;
    } dp_status_t;

    localparam logic        [23:0] ENERGY_MAX    = 24'h800000;
    localparam logic signed [32:0] SHAKE_SCALE   = 33'sd13421773;
    localparam logic signed [32:0] NEG_RADIUS_X2 = -33'sd2136746230;
    localparam logic signed [32:0] RADIUS_SQ     = 33'sd1063031249;
    localparam logic signed [32:0] SOUND_DECAY   = 33'sd1020054733;
    localparam logic signed [32:0] Q28_ONE       = 33'sd268435456;

    localparam longint      Q30_ONE_L    = 64'sd1073741824;
    localparam longint      RADIUS_X2_L  = 64'sd2136746230;
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;

    localparam logic [23:0] RESET_PHASE [3] = '{24'd1065220, 24'd852176, 24'd1278264};

    // cos(x), x in [0, pi/2] as Q30 radians, by Horner-form Taylor series
    // (terms k = 10 down to 1, divisor (2k-1)(2k))
    function automatic longint cos_quarter(input longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE_L;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd380;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd306;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd240;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd182;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd132;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd90;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd56;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd30;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd12;
        t  = Q30_ONE_L - ((x2 * t) >>> 30) / 64'sd2;
        return t;
    endfunction

    // cos of a phase given as a fraction of a turn in 32 bits
    function automatic longint cos_from_turn(input logic [63:0] turn);
        logic [63:0] p;
        logic        neg;
        logic [63:0] xr;
        longint      c;
        p   = turn;
        neg = 1'b0;
        if (p > 64'h8000_0000) begin
            p = 64'h1_0000_0000 - p;
        end
        if (p > 64'h4000_0000) begin
            p   = 64'h8000_0000 - p;
            neg = 1'b1;
        end
        xr = (p * TWO_PI_Q30) >> 32;
        c  = cos_quarter(longint'(xr));
        return neg ? -c : c;
    endfunction

    function automatic longint coeff_of_cos(input longint c);
        return (-RADIUS_X2_L * c) >>> 30;
    endfunction

endpackage

@@ hw/rtl/bss_ctrl.sv @@
// Sequencer for the bamboo shaker: steps the datapath through one item.
`include "bamboo_shaker_synth_unit_defines.svh"
module bss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  bss_pkg::dp_status_t  status,
    output bss_pkg::dp_cmd_t     cmd
);
    import bss_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_E1   = 5'd1;
    localparam logic [4:0] ST_E2   = 5'd2;
    localparam logic [4:0] ST_C1   = 5'd3;
    localparam logic [4:0] ST_RJ   = 5'd4;
    localparam logic [4:0] ST_PH   = 5'd5;
    localparam logic [4:0] ST_CS   = 5'd6;
    localparam logic [4:0] ST_CF   = 5'd7;
    localparam logic [4:0] ST_XL   = 5'd8;
    localparam logic [4:0] ST_XH   = 5'd9;
    localparam logic [4:0] ST_DL   = 5'd10;
    localparam logic [4:0] ST_DH   = 5'd11;
    localparam logic [4:0] ST_R0L  = 5'd12;
    localparam logic [4:0] ST_R0H  = 5'd13;
    localparam logic [4:0] ST_R1L  = 5'd14;
    localparam logic [4:0] ST_R1H  = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] ridx_reg, ridx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;
    logic       out_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_fire = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        ridx_next  = ridx_reg;
        cmd.ridx   = ridx_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_E1;
                end
            end
            ST_E1: begin
                cmd.op     = OP_E1;
                state_next = ST_E2;
            end
            ST_E2: begin
                cmd.op     = OP_E2;
                ridx_next  = 2'd0;
                state_next = status.collide ? ST_C1 : ST_XL;
            end
            ST_C1: begin
                cmd.op     = OP_C1;
                state_next = ST_RJ;
            end
            ST_RJ: begin
                cmd.op     = OP_RJ;
                state_next = ST_PH;
            end
            ST_PH: begin
                cmd.op     = OP_PH;
                state_next = ST_CS;
            end
            ST_CS: begin
                cmd.op     = OP_CS;
                state_next = ST_CF;
            end
            ST_CF: begin
                cmd.op = OP_CF;
                if (ridx_reg == 2'd2) begin
                    ridx_next  = 2'd0;
                    state_next = ST_XL;
                end else begin
                    ridx_next  = ridx_reg + 2'd1;
                    state_next = ST_RJ;
                end
            end
            ST_XL: begin
                cmd.op     = OP_XL;
                state_next = ST_XH;
            end
            ST_XH: begin
                cmd.op     = OP_XH;
                state_next = ST_DL;
            end
            ST_DL: begin
                cmd.op     = OP_DL;
                state_next = ST_DH;
            end
            ST_DH: begin
                cmd.op     = OP_DH;
                ridx_next  = 2'd0;
                state_next = ST_R0L;
            end
            ST_R0L: begin
                cmd.op     = OP_R0L;
                state_next = ST_R0H;
            end
            ST_R0H: begin
                cmd.op     = OP_R0H;
                state_next = ST_R1L;
            end
            ST_R1L: begin
                cmd.op     = OP_R1L;
                state_next = ST_R1H;
            end
            ST_R1H: begin
                cmd.op = OP_R1H;
                if (ridx_reg == 2'd2) begin
                    ridx_next  = 2'd0;
                    state_next = ST_OUT;
                end else begin
                    ridx_next  = ridx_reg + 2'd1;
                    state_next = ST_R0L;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ridx_next  = 2'd0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ridx_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ridx_reg     <= ridx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `BSS_ASSERT_NEXT(a_load_starts_energy, accept, state_reg == ST_E1, "accepted item did not start")
    `BSS_ASSERT_NEXT(a_out_loads, out_fire, m_tvalid_reg && (state_reg == ST_IDLE), "result not presented")
    `BSS_ASSERT(a_ridx_range, 1'b1, ridx_reg != 2'd3, "resonator index out of range")

endmodule

@@ hw/rtl/bss_dpath.sv @@
// Datapath for the bamboo shaker: state, config registers, shared multiplier, cosine table.
`include "bamboo_shaker_synth_unit_defines.svh"
module bss_dpath #(
    parameter int SIGNAL_WIDTH    = 32,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bss_pkg::dp_cmd_t                     cmd,
    output bss_pkg::dp_status_t                  status,
    input  logic                                 cfg_we,
    input  logic [bss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [bss_pkg::S_TDATA_W-1:0]        in_data,
    input  logic                                 in_clear,
    output logic [bss_pkg::M_TDATA_W-1:0]        sample_out
);
    import bss_pkg::*;

    localparam int SW   = SIGNAL_WIDTH;
    localparam int PW   = SW + 33;
    localparam int SUMW = (SW + 2 > 33) ? SW + 2 : 33;
    localparam int IW   = $clog2(COS_TABLE_DEPTH);
    localparam int IDXW = 25 + IW;

    localparam logic signed [PW-1:0] SIG_MAX_W = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PW-1:0] SIG_MIN_W = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SUMW-1:0] OUT_MAX_W = {{(SUMW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUMW-1:0] OUT_MIN_W = {{(SUMW-31){1'b1}}, {31{1'b0}}};

    // configuration
    logic        [12:0] tube_reg;
    logic        [27:0] gain_reg;
    logic        [24:0] decay_reg;
    logic        [23:0] freq_reg;
    logic signed [15:0] spread_reg;
    logic signed [15:0] rand_reg;

    // model state
    logic        [23:0]   energy_reg;
    logic signed [SW-1:0] level_reg;
    logic signed [SW-1:0] h0_reg [3];
    logic signed [SW-1:0] h1_reg [3];
    logic signed [31:0]   coeff_reg [3];
    logic                 collide_reg;

    // per-item work registers
    logic signed [14:0]   nc_reg, nl_reg, nu_reg, ne_reg;
    logic        [23:0]   shake_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [32:0]   m_reg;
    logic        [23:0]   phase_reg;
    logic signed [31:0]   cos_reg;
    logic signed [SW-1:0] x_reg;
    logic signed [PW-1:0] yacc_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic        [31:0]   sample_reg;

    // cosine table, one full turn
    logic signed [31:0] cos_rom [COS_TABLE_DEPTH];
    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        localparam logic [63:0] TURN = (64'(g) << 32) / 64'(COS_TABLE_DEPTH);
        assign cos_rom[g] = 32'(cos_from_turn(TURN));
    end

    // reset coefficients
    logic signed [31:0] coeff_rst [3];
    for (genvar r = 0; r < 3; r++) begin : g_rst
        localparam logic [63:0] RIDX =
            ((64'(RESET_PHASE[r]) * 64'(COS_TABLE_DEPTH) + 64'h800000) >> 24)
            % 64'(COS_TABLE_DEPTH);
        localparam logic [63:0] RTURN = (RIDX << 32) / 64'(COS_TABLE_DEPTH);
        assign coeff_rst[r] = 32'(coeff_of_cos(cos_from_turn(RTURN)));
    end

    function automatic logic signed [SW-1:0] sat_sig(input logic signed [PW-1:0] v);
        if (v > SIG_MAX_W) begin
            return SW'(SIG_MAX_W);
        end else if (v < SIG_MIN_W) begin
            return SW'(SIG_MIN_W);
        end
        return SW'(v);
    endfunction

    function automatic logic [23:0] sat_energy(input logic [24:0] e);
        if (e > 25'(ENERGY_MAX)) begin
            return ENERGY_MAX;
        end
        return e[23:0];
    endfunction

    // shared multiplier
    logic signed [SW-1:0] wide_src;
    logic signed [32:0]   wide_lo, wide_hi;
    logic signed [14:0]   jit;
    logic signed [32:0]   mul_a, mul_b;
    logic signed [65:0]   prod;
    logic signed [PW-1:0] prod_w;
    logic signed [PW-1:0] full;
    logic signed [PW-1:0] full_q30;

    always_comb begin
        case (cmd.op)
            OP_R0L, OP_R0H: wide_src = h0_reg[cmd.ridx];
            OP_R1L, OP_R1H: wide_src = h1_reg[cmd.ridx];
            default:        wide_src = level_reg;
        endcase
        case (cmd.ridx)
            2'd1:    jit = nl_reg;
            2'd2:    jit = nu_reg;
            default: jit = nc_reg;
        endcase
    end

    assign wide_lo = {17'd0, wide_src[15:0]};
    assign wide_hi = {{(49-SW){wide_src[SW-1]}}, wide_src[SW-1:16]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_E1: begin
                mul_a = 33'(shake_reg);
                mul_b = SHAKE_SCALE;
            end
            OP_E2: begin
                mul_a = 33'(energy_reg);
                mul_b = 33'(decay_reg);
            end
            OP_C1: begin
                mul_a = 33'(gain_reg);
                mul_b = 33'(energy_reg);
            end
            OP_RJ: begin
                mul_a = 33'(rand_reg);
                mul_b = 33'(jit);
            end
            OP_PH: begin
                mul_a = 33'(freq_reg);
                mul_b = m_reg;
            end
            OP_CF: begin
                mul_a = 33'(cos_reg);
                mul_b = NEG_RADIUS_X2;
            end
            OP_XL, OP_XH: begin
                mul_a = (cmd.op == OP_XL) ? wide_lo : wide_hi;
                mul_b = 33'(ne_reg);
            end
            OP_DL, OP_DH: begin
                mul_a = (cmd.op == OP_DL) ? wide_lo : wide_hi;
                mul_b = SOUND_DECAY;
            end
            OP_R0L, OP_R0H: begin
                mul_a = (cmd.op == OP_R0L) ? wide_lo : wide_hi;
                mul_b = 33'(coeff_reg[cmd.ridx]);
            end
            OP_R1L, OP_R1H: begin
                mul_a = (cmd.op == OP_R1L) ? wide_lo : wide_hi;
                mul_b = RADIUS_SQ;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_w   = PW'(prod);
    assign full     = (prod_w <<< 16) + acc_reg;
    assign full_q30 = full >>> 30;

    // result candidates
    logic        [24:0]   e1_sum;
    logic signed [PW-1:0] lvl_sum;
    logic signed [32:0]   rj_p;
    logic signed [32:0]   spread_term;
    logic signed [32:0]   m_new;
    logic signed [SW-1:0] y_new;
    logic [IDXW-1:0]      idx_sum;
    logic [IW:0]          idx_wide;
    logic [IW-1:0]        cs_idx;

    assign e1_sum      = 25'(energy_reg) + 25'(prod[50:27]);
    assign lvl_sum     = PW'(level_reg) + PW'(prod[51:23]);
    assign rj_p        = prod[32:0];
    assign spread_term = 33'(spread_reg) <<< 14;
    assign y_new       = sat_sig(yacc_reg - full_q30);

    always_comb begin
        case (cmd.ridx)
            2'd1:    m_new = Q28_ONE - spread_term + rj_p;
            2'd2:    m_new = Q28_ONE + (spread_term <<< 1) + (rj_p <<< 1);
            default: m_new = Q28_ONE + rj_p;
        endcase
    end

    // phase to nearest table entry, wrapping the top entry to zero
    assign idx_sum  = IDXW'(phase_reg) * IDXW'(COS_TABLE_DEPTH) + IDXW'(24'h800000);
    assign idx_wide = idx_sum[IDXW-1:24];
    assign cs_idx   = (idx_wide >= (IW+1)'(COS_TABLE_DEPTH)) ? '0 : idx_wide[IW-1:0];

    // state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tube_reg    <= RST_TUBE_COUNT;
            gain_reg    <= RST_LEVEL_GAIN;
            decay_reg   <= RST_SYSTEM_DECAY;
            freq_reg    <= RST_RES_FREQ;
            spread_reg  <= '0;
            rand_reg    <= '0;
            energy_reg  <= '0;
            level_reg   <= '0;
            collide_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                h0_reg[i]    <= '0;
                h1_reg[i]    <= '0;
                coeff_reg[i] <= coeff_rst[i];
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TUBE_COUNT:   tube_reg   <= cfg_data[12:0];
                    REG_LEVEL_GAIN:   gain_reg   <= cfg_data[27:0];
                    REG_SYSTEM_DECAY: decay_reg  <= cfg_data[24:0];
                    REG_RES_FREQ:     freq_reg   <= cfg_data[23:0];
                    REG_RES_SPREAD:   spread_reg <= signed'(cfg_data[15:0]);
                    REG_RES_RANDOM:   rand_reg   <= signed'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD: begin
                    collide_reg <= in_data[F_DRAW_LSB +: 13] < tube_reg;
                    if (in_clear) begin
                        level_reg <= '0;
                        for (int i = 0; i < 3; i++) begin
                            h0_reg[i] <= '0;
                            h1_reg[i] <= '0;
                        end
                    end
                end
                OP_E1: energy_reg <= sat_energy(e1_sum);
                OP_E2: energy_reg <= sat_energy(prod[48:24]);
                OP_C1: level_reg  <= sat_sig(lvl_sum);
                OP_CF: coeff_reg[cmd.ridx] <= prod[61:30];
                OP_DH: level_reg  <= SW'(full_q30);
                OP_R1H: begin
                    h1_reg[cmd.ridx] <= h0_reg[cmd.ridx];
                    h0_reg[cmd.ridx] <= y_new;
                end
                default: ;
            endcase
        end
    end

    // per-item work registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                nc_reg    <= signed'(in_data[F_NC_LSB +: 15]);
                nl_reg    <= signed'(in_data[F_NL_LSB +: 15]);
                nu_reg    <= signed'(in_data[F_NU_LSB +: 15]);
                ne_reg    <= signed'(in_data[F_NE_LSB +: 15]);
                shake_reg <= in_data[F_SHAKE_LSB +: 24];
                sum_reg   <= '0;
            end
            OP_RJ: m_reg     <= m_new;
            OP_PH: phase_reg <= prod[51:28];
            OP_CS: cos_reg   <= cos_rom[cs_idx];
            OP_XL, OP_DL, OP_R0L, OP_R1L: acc_reg <= prod_w;
            OP_XH: x_reg    <= sat_sig(full >>> 14);
            OP_R0H: yacc_reg <= PW'(x_reg) - full_q30;
            OP_R1H: sum_reg  <= sum_reg + SUMW'(y_new);
            OP_OUT: begin
                if (sum_reg > OUT_MAX_W) begin
                    sample_reg <= 32'(OUT_MAX_W);
                end else if (sum_reg < OUT_MIN_W) begin
                    sample_reg <= 32'(OUT_MIN_W);
                end else begin
                    sample_reg <= 32'(sum_reg);
                end
            end
            default: ;
        endcase
    end

    assign status.collide = collide_reg;
    assign sample_out     = sample_reg;

    `BSS_ASSERT(a_energy_bound, 1'b1, energy_reg <= ENERGY_MAX, "shake energy above one")
    `BSS_ASSERT_NEXT(a_clear_level, (cmd.op == OP_LOAD) && in_clear, level_reg == '0, "clear missed level")
    `BSS_ASSERT(a_idx_bound, cmd.op == OP_CS, 32'(cs_idx) < 32'(COS_TABLE_DEPTH), "table index out of range")

endmodule

@@ hw/rtl/bamboo_shaker_synth_unit.sv @@
// Top level of the bamboo shaker synth: sequencer plus datapath.
//
// Usage:
//  - Input channel s_*: one item per audio tick. s_tdata carries, from bit 0 up,
//    collide_draw, the four noise values and shake_amount; s_tuser[0] is
//    clear_filters. s_tready is high only while the block is idle.
//  - Output channel m_*: one 32-bit Q8.24 sample per input item on m_tdata.
//  - Config port: cfg_we writes cfg_data into register cfg_index at the clock
//    edge; indexes 6 and 7 are ignored. Write only while idle.
// Timing:
//  - One 33x33 multiplier is shared by every product, at most one product per
//    cycle while an item is stepped through; wide signal products take two
//    passes. That multiplier sets the rate.
//  - An item with a collision also redraws its coefficients, four steps per
//    resonator. The next item is accepted the cycle after the result is loaded.
//  - m_tdata is registered; if the receiver stalls, the finished sample waits
//    there and the next item stops only at its own output step.
// Reset (aresetn low, synchronous): registers take their defaults, energy,
// level and resonator history clear, coefficients return to 2800/2240/3360 Hz.
module bamboo_shaker_synth_unit #(
    parameter int SIGNAL_WIDTH    = 32,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // collide_draw[12:0], noise_centre[27:13], noise_lower[42:28],
    // noise_upper[57:43], noise_excite[72:58], shake_amount[96:73], zero pad
    input  logic [bss_pkg::S_TDATA_W-1:0]     s_tdata,
    // clear_filters[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_out[31:0]
    output logic [bss_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [bss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bss_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bss_dpath #(
        .SIGNAL_WIDTH    (SIGNAL_WIDTH),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_data    (s_tdata),
        .in_clear   (s_tuser[0]),
        .sample_out (m_tdata)
    );

endmodule

@@ tb/bss_sample_checker.sv @@
// Watches the bamboo shaker channels, predicts every sample and compares.
module bss_sample_checker
    import bss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    localparam int     SIG_W     = 32;
    localparam int     TBL_DEPTH = 1024;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint R2_Q30    = 64'sd2136746230;
    localparam longint RSQ_Q30   = 64'sd1063031249;
    localparam longint DECAY_Q30 = 64'sd1020054733;
    localparam logic [63:0] TURN_Q30 = 64'd6746518852;
    localparam logic [63:0] E_MAX    = 64'd8388608;

    longint cos_lut [TBL_DEPTH];

    logic [12:0] tubes;
    logic [27:0] gain;
    logic [24:0] sys_decay;
    logic [23:0] freq;
    longint      spread, jitter;

    logic [63:0] energy;
    longint      level;
    longint      coeff [3];
    longint      hist [6];

    logic [31:0] expected_samples [$];

    assign pending = expected_samples.size();

    function automatic longint clip(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        longint bh, bl;
        bh = b >>> 16;
        bl = b - bh * 65536;
        return (a * bh + ((a * bl) >>> 16)) >>> 14;
    endfunction

    function automatic longint series_cos(longint x);
        longint x2, t;
        int     k;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30;
        for (k = 10; k >= 1; k--)
            t = ONE_Q30 - ((x2 * t) >>> 30) / longint'((2 * k - 1) * (2 * k));
        return t;
    endfunction

    function automatic longint coeff_at(logic [63:0] phase);
        logic [63:0] idx;
        idx = ((phase & 64'hFFFFFF) * TBL_DEPTH + 64'd8388608) >> 24;
        if (idx >= TBL_DEPTH) idx = idx - TBL_DEPTH;
        return (-R2_Q30 * cos_lut[idx]) >>> 30;
    endfunction

    function automatic logic [63:0] phase_of(longint m28);
        longint      prod;
        logic [63:0] u;
        prod = longint'({40'd0, freq}) * m28;
        u    = prod;
        return (u >> 28) & 64'hFFFFFF;
    endfunction

    initial begin
        logic [63:0] p, xr;
        logic        neg;
        longint      c;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            p   = (64'(i) << 32) / TBL_DEPTH;
            neg = 1'b0;
            if (p > 64'h8000_0000) p = 64'h1_0000_0000 - p;
            if (p > 64'h4000_0000) begin
                p   = 64'h8000_0000 - p;
                neg = 1'b1;
            end
            xr = (p * TURN_Q30) >> 32;
            c  = series_cos(longint'(xr));
            cos_lut[i] = neg ? -c : c;
        end
    end

    task automatic predict_sample(input logic [S_TDATA_W-1:0] d, input logic clr);
        logic [63:0] draw, shake;
        longint      nc, nl, nu, ne, x, y, sum;
        draw  = 64'(d[F_DRAW_LSB +: 13]);
        nc    = longint'($signed(d[F_NC_LSB +: 15]));
        nl    = longint'($signed(d[F_NL_LSB +: 15]));
        nu    = longint'($signed(d[F_NU_LSB +: 15]));
        ne    = longint'($signed(d[F_NE_LSB +: 15]));
        shake = 64'(d[F_SHAKE_LSB +: 24]);
        if (clr) begin
            for (int i = 0; i < 6; i++) hist[i] = 0;
            level = 0;
        end
        energy = energy + ((shake * 64'd13421773) >> 27);
        if (energy > E_MAX) energy = E_MAX;
        energy = (energy * 64'(sys_decay)) >> 24;
        if (energy > E_MAX) energy = E_MAX;
        if (draw < 64'(tubes)) begin
            level = clip(level + longint'((64'(gain) * energy) >> 23), SIG_W);
            coeff[0] = coeff_at(phase_of(ONE_Q30 / 4 + jitter * nc));
            coeff[1] = coeff_at(phase_of(ONE_Q30 / 4 - spread * 16384 + jitter * nl));
            coeff[2] = coeff_at(phase_of(ONE_Q30 / 4 + 2 * spread * 16384
                                         + 2 * jitter * nu));
        end
        x     = clip((level * ne) >>> 14, SIG_W);
        level = q30_mul(level, DECAY_Q30);
        sum   = 0;
        for (int r = 0; r < 3; r++) begin
            y = clip(x - q30_mul(hist[2*r], coeff[r]) - q30_mul(hist[2*r+1], RSQ_Q30),
                     SIG_W);
            hist[2*r+1] = hist[2*r];
            hist[2*r]   = y;
            sum = sum + y;
        end
        expected_samples.push_back(32'(clip(sum, 32)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            tubes     = RST_TUBE_COUNT;
            gain      = RST_LEVEL_GAIN;
            sys_decay = RST_SYSTEM_DECAY;
            freq      = RST_RES_FREQ;
            spread    = 0;
            jitter    = 0;
            energy    = 0;
            level     = 0;
            for (int i = 0; i < 6; i++) hist[i] = 0;
            coeff[0] = coeff_at(64'd1065220);
            coeff[1] = coeff_at(64'd852176);
            coeff[2] = coeff_at(64'd1278264);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TUBE_COUNT:   tubes     = cfg_data[12:0];
                    REG_LEVEL_GAIN:   gain      = cfg_data[27:0];
                    REG_SYSTEM_DECAY: sys_decay = cfg_data[24:0];
                    REG_RES_FREQ:     freq      = cfg_data[23:0];
                    REG_RES_SPREAD:   spread    = longint'($signed(cfg_data[15:0]));
                    REG_RES_RANDOM:   jitter    = longint'($signed(cfg_data[15:0]));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_sample(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t unexpected sample: expected none actual %h", $time, m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    logic [31:0] want;
                    want = expected_samples.pop_front();
                    if (want !== m_tdata) begin
                        $display("%0t sample_out mismatch: expected %h actual %h",
                                 $time, want, m_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// Stimulus and verdict for the bamboo shaker synth regression.
module tb;
    import bss_pkg::*;

    // Idle cycles allowed with no accept on either side before giving up.
    // The worst item plus an output stall is far under this.
    localparam int WATCHDOG_LIMIT = 5000;
    // Settle time after the last result, longer than an item with a collision takes.
    localparam int SETTLE_CYCLES  = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit no_idle = 1'b0;     // last part of the run: no gaps on either side
    logic [12:0] cur_tubes = RST_TUBE_COUNT;

    always #6 aclk = ~aclk;

    bamboo_shaker_synth_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bss_sample_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: any accept on either channel resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("bamboo_shaker_synth_unit regression: fail");
                $finish;
            end
        end
    end

    // Receiver: bursts of backpressure, then stretches of ready.
    initial begin
        @(posedge aclk);
        forever begin
            if (no_idle || ($urandom % 3 != 0)) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    // One item: held until accepted, then maybe a gap with s_tvalid low.
    task automatic send_item(input logic [12:0] draw, input logic [14:0] nc,
                             input logic [14:0] nl, input logic [14:0] nu,
                             input logic [14:0] ne, input logic [23:0] shake,
                             input logic clr);
        s_tdata  <= {7'd0, shake, ne, nu, nl, nc, draw};
        s_tuser  <= clr;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!no_idle && ($urandom % 4 == 0)) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Random item biased toward collisions and toward zero or extreme shakes so the resonators ring.
    task automatic send_random_item();
        logic [12:0] draw;
        logic [23:0] shake;
        case ($urandom % 4)
            0, 1:    draw = 13'($urandom_range(0, 15));
            2:       draw = (cur_tubes == 0) ? 13'd0 : cur_tubes - 13'($urandom_range(0, 1));
            default: draw = 13'($urandom);
        endcase
        case ($urandom % 16)
            0:       shake = 24'h800000;
            1, 2:    shake = 24'($urandom);
            3:       shake = 24'hFFFFFF;
            default: shake = 24'd0;
        endcase
        send_item(draw, 15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom), shake,
                  ($urandom % 32) == 0);
    endtask

    // Sender holds off until every expected sample is out, then lets the
    // block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_TUBE_COUNT) cur_tubes = val[12:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Load a whole register set, block idle.
    task automatic load_regs(input logic [12:0] tubes, input logic [27:0] gain,
                             input logic [24:0] dec, input logic [23:0] freq,
                             input logic [15:0] spr, input logic [15:0] jit);
        write_reg(REG_TUBE_COUNT, 28'(tubes));
        write_reg(REG_LEVEL_GAIN, gain);
        write_reg(REG_SYSTEM_DECAY, 28'(dec));
        write_reg(REG_RES_FREQ, 28'(freq));
        write_reg(REG_RES_SPREAD, 28'(spr));
        write_reg(REG_RES_RANDOM, 28'(jit));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset defaults: field extremes, clear, big shakes.
        send_item(13'd0, 15'h4000, 15'h3FFF, 15'h4000, 15'h3FFF, 24'h800000, 1'b0);
        send_item(13'd4, 15'h3FFF, 15'h4000, 15'h3FFF, 15'h4000, 24'h000000, 1'b0);
        send_item(13'h1FFF, 15'h0000, 15'h0000, 15'h0000, 15'h4000, 24'hFFFFFF, 1'b0);
        send_item(13'd4096, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 24'h000001, 1'b0);
        send_item(13'd5, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555, 24'h000000, 1'b0);
        send_item(13'd1, 15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 24'h7FFFFF, 1'b1);
        send_item(13'd2, 15'h1234, 15'h6543, 15'h0F0F, 15'h70F0, 24'hAAAAAA, 1'b0);
        send_item(13'h1AAA, 15'h0001, 15'h7FFE, 15'h0001, 15'h3FFF, 24'h555555, 1'b0);
        send_item(13'd0, 15'h4000, 15'h4000, 15'h4000, 15'h4000, 24'h000000, 1'b1);
        drain();

        // Decay above one, huge gain and widest spread/jitter: saturation.
        load_regs(13'd4096, 28'd201326592, 25'h1FFFFFF, 24'h800000, 16'h8000, 16'h7FFF);
        write_reg(3'd6, 28'hFFFFFFF);   // out-of-range indexes are ignored
        write_reg(3'd7, 28'h0000000);
        send_item(13'd0, 15'h3FFF, 15'h4000, 15'h3FFF, 15'h3FFF, 24'hFFFFFF, 1'b0);
        send_item(13'd4095, 15'h4000, 15'h3FFF, 15'h4000, 15'h4000, 24'h800000, 1'b0);
        send_item(13'd4096, 15'h3FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF, 24'h000000, 1'b0);
        send_item(13'd1, 15'h4000, 15'h4000, 15'h4000, 15'h4000, 24'h000000, 1'b0);
        drain();

        // Tube count zero: never a collision; aliased frequency.
        load_regs(13'd0, 28'd0, 25'd0, 24'hFFFFFF, 16'h7FFF, 16'h8000);
        send_item(13'd0, 15'h3FFF, 15'h4000, 15'h3FFF, 15'h3FFF, 24'hFFFFFF, 1'b0);
        send_item(13'h1FFF, 15'h4000, 15'h3FFF, 15'h4000, 15'h4000, 24'h800000, 1'b1);
        drain();

        // Random phases, each with its own register set; extremes mixed in.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       load_regs(RST_TUBE_COUNT, RST_LEVEL_GAIN, RST_SYSTEM_DECAY,
                                   RST_RES_FREQ, 16'd0, 16'd0);
                1:       load_regs(13'd1, 28'd201326592, 25'd16777216, 24'd0,
                                   16'h8000, 16'h8000);
                2:       load_regs(13'd4096, 28'd50000000, 25'd16000000, 24'd8388608,
                                   16'h7FFF, 16'h7FFF);
                3:       load_regs(13'h1FFF, 28'hFFFFFFF, 25'h1FFFFFF, 24'hFFFFFF,
                                   16'h1000, 16'hF000);
                default: load_regs(13'($urandom_range(1, 64)),
                                   28'($urandom_range(0, 201326592)),
                                   25'($urandom_range(15000000, 16777216)),
                                   24'($urandom_range(0, 8388608)),
                                   16'($urandom), 16'($urandom));
            endcase
            if (ph == 7) no_idle = 1'b1;
            for (int n = 0; n < 125; n++) begin
                send_random_item();
                // Mid-phase hold-off until the pipeline is empty.
                if (n == 60 && ph == 4) drain();
            end
            drain();
        end

        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("bamboo_shaker_synth_unit regression: pass");
        end else begin
            $display("bamboo_shaker_synth_unit regression: fail");
        end
        $finish;
    end
endmodule
